// ===== sv/dpl_pkg.sv =====
package dpl_pkg;

  // Field widths.
  localparam int TS_WIDTH     = 36;
  localparam int PRICE_WIDTH  = 40;
  localparam int LEVEL_WIDTH  = 48;
  localparam int OFFSET_WIDTH = 18;
  localparam int METHOD_WIDTH = 2;
  localparam int DAY_WIDTH    = 21;
  localparam int NUM_LEVELS   = 7;

  // Level formula codes.
  localparam logic [METHOD_WIDTH-1:0] METHOD_STANDARD  = 2'd0;
  localparam logic [METHOD_WIDTH-1:0] METHOD_FIBONACCI = 2'd1;
  localparam logic [METHOD_WIDTH-1:0] METHOD_CAMARILLA = 2'd2;

  // Positions of the levels.
  localparam int LVL_P  = 0;
  localparam int LVL_R1 = 1;
  localparam int LVL_R2 = 2;
  localparam int LVL_R3 = 3;
  localparam int LVL_S1 = 4;
  localparam int LVL_S2 = 5;
  localparam int LVL_S3 = 6;

  // Day number: 86400 = 128 * 675. The shifted value is biased so that it is never
  // negative, then divided by 675 with a reciprocal that is exact below 2**31.
  localparam int DAY_SUM_W       = TS_WIDTH + 2;
  localparam int DAY_SHIFT       = 7;
  localparam int DAY_Y_W         = DAY_SUM_W - DAY_SHIFT;
  localparam int DAY_ODD         = 675;
  localparam int DAY_BIAS_DAYS   = 4;
  localparam logic [DAY_Y_W-1:0] DAY_BIAS = DAY_Y_W'(DAY_BIAS_DAYS * DAY_ODD);
  localparam int DAY_RECIP_W     = 32;
  localparam logic [DAY_RECIP_W-1:0] DAY_RECIP = 32'd3257812231;
  localparam int DAY_RECIP_SHIFT = 41;
  localparam int DAY_PROD_W      = DAY_Y_W + DAY_RECIP_W;

  // Pivot: floor((H + L + C) / 3) through a reciprocal split into four partial products.
  localparam int SUM_WIDTH    = PRICE_WIDTH + 2;
  localparam int DIV3_SHIFT   = SUM_WIDTH + 2;
  localparam int DIV3_RECIP_W = SUM_WIDTH + 1;
  localparam logic [DIV3_RECIP_W-1:0] DIV3_RECIP =
    DIV3_RECIP_W'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);
  localparam int DIV_LO_W     = SUM_WIDTH / 2;
  localparam int DIV_PP_W     = (SUM_WIDTH - DIV_LO_W) + (DIV3_RECIP_W - DIV_LO_W);
  localparam int DIV_PROD_W   = SUM_WIDTH + DIV3_RECIP_W;

  // Q1.16 factors of the Fibonacci and Camarilla levels.
  localparam int FACTOR_W    = 17;
  localparam int FACTOR_FRAC = 16;
  typedef logic [2:0][FACTOR_W-1:0] factor_set_t;
  localparam factor_set_t FIB_FACTOR = {17'd65536, 17'd40501, 17'd25035};
  localparam factor_set_t CAM_FACTOR = {17'd18022, 17'd12015, 17'd6007};

  localparam int RANGE_W     = PRICE_WIDTH + 1;
  localparam int TERM_PROD_W = RANGE_W + FACTOR_W + 1;
  localparam int TERM_W      = TERM_PROD_W - FACTOR_FRAC;
  localparam int LV_W        = LEVEL_WIDTH + 2;

  typedef logic [LEVEL_WIDTH-1:0] level_t;

  typedef struct packed {
    logic [TS_WIDTH-1:0]    timestamp;
    logic [PRICE_WIDTH-1:0] high_price;
    logic [PRICE_WIDTH-1:0] low_price;
    logic [PRICE_WIDTH-1:0] close_price;
  } candle_t;

  typedef struct packed {
    logic                          levels_valid;
    logic signed [LEVEL_WIDTH-1:0] pivot_level;
    logic signed [LEVEL_WIDTH-1:0] resist_one;
    logic signed [LEVEL_WIDTH-1:0] resist_two;
    logic signed [LEVEL_WIDTH-1:0] resist_three;
    logic signed [LEVEL_WIDTH-1:0] support_one;
    logic signed [LEVEL_WIDTH-1:0] support_two;
    logic signed [LEVEL_WIDTH-1:0] support_three;
  } pivot_t;

  // One classified candle: form is set when it opens a new day after a finished one,
  // and then the prices are that finished day's high, low and close.
  typedef struct packed {
    logic                   form;
    logic [PRICE_WIDTH-1:0] day_high;
    logic [PRICE_WIDTH-1:0] day_low;
    logic [PRICE_WIDTH-1:0] day_close;
  } qentry_t;

endpackage

// ===== sv/daily_pivot_levels_top.sv =====
// Daily pivot levels over a stream of price candles. Each accepted candle is bucketed
// into a day by floor((timestamp + session_offset) / 86400); the block tracks the day's
// high, low and last close, and when the bucket changes it forms P, R1..R3 and S1..S3
// of the finished day with the standard, Fibonacci or Camarilla formulas chosen by
// pivot_method. Every candle yields exactly one result transaction carrying the levels
// of the most recently finished day, or levels_valid low and zero levels while no day
// has finished. One candle is taken per clock cycle sustained while candle_stall is low;
// that figure is set by the compare and update of the running day state as a candle
// enters the queue. A candle passes f1 and f2 (day number), the queue of QUEUE_DEPTH
// entries, b1 to b3 (levels) and the output register. The queue lets candles keep
// arriving for a while when results are stalled. The user must write the registers
// through the APB port only while no transaction is in flight; the block does not
// enforce this. pivot_method is at byte address 0, session_offset at byte address 4.
module daily_pivot_levels_top import dpl_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        candle_valid,
  output logic        candle_stall,
  input  candle_t     candle,
  output logic        pivot_valid,
  input  logic        pivot_stall,
  output pivot_t      pivot
);

  localparam logic REG_PIVOT_METHOD   = 1'b0;
  localparam logic REG_SESSION_OFFSET = 1'b1;

  logic [METHOD_WIDTH-1:0]        pivot_method;
  logic signed [OFFSET_WIDTH-1:0] session_offset;
  logic                           cfg_write;
  logic                           q_full;
  logic                           q_push;
  qentry_t                        q_wdata;
  logic                           q_pop;
  logic                           q_valid;
  qentry_t                        q_rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot_method   <= METHOD_STANDARD;
      session_offset <= '0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_PIVOT_METHOD:   pivot_method   <= pwdata[METHOD_WIDTH-1:0];
        REG_SESSION_OFFSET: session_offset <= pwdata[OFFSET_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PIVOT_METHOD:   prdata = {{(32-METHOD_WIDTH){1'b0}}, pivot_method};
      REG_SESSION_OFFSET: prdata = {{(32-OFFSET_WIDTH){session_offset[OFFSET_WIDTH-1]}},
                                    session_offset};
      default:            prdata = '0;
    endcase
  end

  dpl_front u_front (
    .clk            (clk),
    .rst            (rst),
    .session_offset (session_offset),
    .candle_valid   (candle_valid),
    .candle_stall   (candle_stall),
    .candle         (candle),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  dpl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_rdata)
  );

  dpl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pivot_method (pivot_method),
    .q_valid      (q_valid),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .pivot_valid  (pivot_valid),
    .pivot_stall  (pivot_stall),
    .pivot        (pivot)
  );

endmodule

// ===== sv/dpl_front.sv =====
module dpl_front import dpl_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic signed [OFFSET_WIDTH-1:0] session_offset,
  input  logic                           candle_valid,
  output logic                           candle_stall,
  input  candle_t                        candle,
  input  logic                           q_full,
  output logic                           q_push,
  output qentry_t                        q_data
);

  logic                   f1_valid;
  logic [DAY_Y_W-1:0]     f1_yb;
  candle_t                f1_candle;
  logic                   f2_valid;
  logic [DAY_WIDTH-1:0]   f2_day;
  candle_t                f2_candle;
  logic                   f1_ready;
  logic                   f2_ready;
  logic [DAY_SUM_W-1:0]   shifted_sum;
  logic [DAY_Y_W-1:0]     yb_next;
  logic [DAY_PROD_W-1:0]  day_prod;
  logic [DAY_WIDTH-1:0]   day_next;

  logic                   have_day;
  logic [DAY_WIDTH-1:0]   current_day;
  logic [PRICE_WIDTH-1:0] day_high;
  logic [PRICE_WIDTH-1:0] day_low;
  logic [PRICE_WIDTH-1:0] day_close;
  logic                   same_day;

  assign f2_ready     = !f2_valid || !q_full;
  assign f1_ready     = !f1_valid || f2_ready;
  assign candle_stall = !f1_ready;
  assign q_push       = f2_valid && !q_full;

  always_comb begin
    shifted_sum = {2'b00, candle.timestamp}
                + {{(DAY_SUM_W-OFFSET_WIDTH){session_offset[OFFSET_WIDTH-1]}}, session_offset};
    yb_next     = shifted_sum[DAY_SUM_W-1:DAY_SHIFT] + DAY_BIAS;
    day_prod    = DAY_PROD_W'(f1_yb) * DAY_PROD_W'(DAY_RECIP);
    day_next    = DAY_WIDTH'(day_prod[DAY_PROD_W-1:DAY_RECIP_SHIFT])
                - DAY_WIDTH'(DAY_BIAS_DAYS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (f1_ready) f1_valid <= candle_valid;
      if (f2_ready) f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_ready && candle_valid) begin
      f1_yb     <= yb_next;
      f1_candle <= candle;
    end
    if (f2_ready && f1_valid) begin
      f2_day    <= day_next;
      f2_candle <= f1_candle;
    end
  end

  // Classification happens as the candle enters the queue, so the running day state
  // is always up to date for the next candle.
  always_comb begin
    same_day         = have_day && (f2_day == current_day);
    q_data.form      = have_day && !same_day;
    q_data.day_high  = day_high;
    q_data.day_low   = day_low;
    q_data.day_close = day_close;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_day <= 1'b0;
    end else if (q_push) begin
      have_day <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      day_close <= f2_candle.close_price;
      if (same_day) begin
        if (f2_candle.high_price > day_high) day_high <= f2_candle.high_price;
        if (f2_candle.low_price < day_low) day_low <= f2_candle.low_price;
      end else begin
        current_day <= f2_day;
        day_high    <= f2_candle.high_price;
        day_low     <= f2_candle.low_price;
      end
    end
  end

endmodule

// ===== sv/dpl_fifo.sv =====
module dpl_fifo import dpl_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  qentry_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    pop_valid,
  output qentry_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qentry_t          entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/dpl_back.sv =====
module dpl_back import dpl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [METHOD_WIDTH-1:0] pivot_method,
  input  logic                    q_valid,
  input  qentry_t                 q_data,
  output logic                    q_pop,
  output logic                    pivot_valid,
  input  logic                    pivot_stall,
  output pivot_t                  pivot
);

  typedef struct packed {
    logic                      form;
    logic [PRICE_WIDTH-1:0]    high;
    logic [PRICE_WIDTH-1:0]    low;
    logic [PRICE_WIDTH-1:0]    close;
    logic [SUM_WIDTH-1:0]      sum3;
    logic [RANGE_W-1:0]        day_range;
  } b1_t;

  typedef struct packed {
    logic                      form;
    logic [PRICE_WIDTH-1:0]    high;
    logic [PRICE_WIDTH-1:0]    low;
    logic [PRICE_WIDTH-1:0]    close;
    logic [RANGE_W-1:0]        day_range;
    logic [DIV_PP_W-1:0]       pp_hh;
    logic [DIV_PP_W-1:0]       pp_hl;
    logic [DIV_PP_W-1:0]       pp_lh;
    logic [DIV_PP_W-1:0]       pp_ll;
    logic [TERM_PROD_W-1:0]    tp0;
    logic [TERM_PROD_W-1:0]    tp1;
    logic [TERM_PROD_W-1:0]    tp2;
  } b2_t;

  typedef struct packed {
    logic                      form;
    logic [PRICE_WIDTH-1:0]    high;
    logic [PRICE_WIDTH-1:0]    low;
    logic [PRICE_WIDTH-1:0]    close;
    logic [RANGE_W-1:0]        day_range;
    logic [PRICE_WIDTH-1:0]    p;
    logic [TERM_W-1:0]         t0;
    logic [TERM_W-1:0]         t1;
    logic [TERM_W-1:0]         t2;
  } b3_t;

  logic b1_valid;
  logic b2_valid;
  logic b3_valid;
  b1_t  b1;
  b2_t  b2;
  b3_t  b3;
  b1_t  b1_next;
  b2_t  b2_next;
  b3_t  b3_next;
  logic b1_ready;
  logic b2_ready;
  logic b3_ready;
  logic out_ready;

  factor_set_t                    factors;
  logic [SUM_WIDTH-DIV_LO_W-1:0]  x_hi;
  logic [DIV_LO_W-1:0]            x_lo;
  logic [DIV3_RECIP_W-DIV_LO_W-1:0] r_hi;
  logic [DIV_LO_W-1:0]            r_lo;
  logic [DIV_PROD_W-1:0]          div_prod;

  logic signed [LV_W-1:0] sp;
  logic signed [LV_W-1:0] sh;
  logic signed [LV_W-1:0] sl;
  logic signed [LV_W-1:0] sc;
  logic signed [LV_W-1:0] sr;
  logic signed [LV_W-1:0] st0;
  logic signed [LV_W-1:0] st1;
  logic signed [LV_W-1:0] st2;
  logic signed [LV_W-1:0] lv [NUM_LEVELS];
  level_t                 fresh [NUM_LEVELS];
  level_t                 held [NUM_LEVELS];
  level_t                 shown [NUM_LEVELS];
  logic                   levels_ready;
  pivot_t                 pivot_next;

  assign out_ready = !pivot_valid || !pivot_stall;
  assign b3_ready  = !b3_valid || out_ready;
  assign b2_ready  = !b2_valid || b3_ready;
  assign b1_ready  = !b1_valid || b2_ready;
  assign q_pop     = q_valid && b1_ready;

  // Stage 1: sum and range of the finished day.
  always_comb begin
    b1_next.form      = q_data.form;
    b1_next.high      = q_data.day_high;
    b1_next.low       = q_data.day_low;
    b1_next.close     = q_data.day_close;
    b1_next.sum3      = SUM_WIDTH'(q_data.day_high) + SUM_WIDTH'(q_data.day_low)
                      + SUM_WIDTH'(q_data.day_close);
    b1_next.day_range = {1'b0, q_data.day_high} - {1'b0, q_data.day_low};
  end

  // Stage 2: partial products of the divide by three, and the scaled range terms.
  always_comb begin
    case (pivot_method)
      METHOD_CAMARILLA: factors = CAM_FACTOR;
      default:          factors = FIB_FACTOR;
    endcase
    x_hi = b1.sum3[SUM_WIDTH-1:DIV_LO_W];
    x_lo = b1.sum3[DIV_LO_W-1:0];
    r_hi = DIV3_RECIP[DIV3_RECIP_W-1:DIV_LO_W];
    r_lo = DIV3_RECIP[DIV_LO_W-1:0];
    b2_next.form      = b1.form;
    b2_next.high      = b1.high;
    b2_next.low       = b1.low;
    b2_next.close     = b1.close;
    b2_next.day_range = b1.day_range;
    b2_next.pp_hh     = DIV_PP_W'(x_hi) * DIV_PP_W'(r_hi);
    b2_next.pp_hl     = DIV_PP_W'(x_hi) * DIV_PP_W'(r_lo);
    b2_next.pp_lh     = DIV_PP_W'(x_lo) * DIV_PP_W'(r_hi);
    b2_next.pp_ll     = DIV_PP_W'(x_lo) * DIV_PP_W'(r_lo);
    b2_next.tp0       = $signed(b1.day_range) * $signed({1'b0, factors[0]});
    b2_next.tp1       = $signed(b1.day_range) * $signed({1'b0, factors[1]});
    b2_next.tp2       = $signed(b1.day_range) * $signed({1'b0, factors[2]});
  end

  // Stage 3: assemble the quotient and floor the terms.
  always_comb begin
    div_prod = (DIV_PROD_W'(b2.pp_hh) << (2 * DIV_LO_W))
             + (DIV_PROD_W'(b2.pp_hl) << DIV_LO_W)
             + (DIV_PROD_W'(b2.pp_lh) << DIV_LO_W)
             + DIV_PROD_W'(b2.pp_ll);
    b3_next.form      = b2.form;
    b3_next.high      = b2.high;
    b3_next.low       = b2.low;
    b3_next.close     = b2.close;
    b3_next.day_range = b2.day_range;
    b3_next.p         = div_prod[DIV3_SHIFT +: PRICE_WIDTH];
    b3_next.t0        = b2.tp0[TERM_PROD_W-1:FACTOR_FRAC];
    b3_next.t1        = b2.tp1[TERM_PROD_W-1:FACTOR_FRAC];
    b3_next.t2        = b2.tp2[TERM_PROD_W-1:FACTOR_FRAC];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
    end else begin
      if (b1_ready) b1_valid <= q_valid;
      if (b2_ready) b2_valid <= b1_valid;
      if (b3_ready) b3_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) b1 <= b1_next;
    if (b2_ready && b1_valid) b2 <= b2_next;
    if (b3_ready && b2_valid) b3 <= b3_next;
  end

  // Stage 4: the seven levels, then the output register.
  always_comb begin
    sp  = $signed({{(LV_W-PRICE_WIDTH){1'b0}}, b3.p});
    sh  = $signed({{(LV_W-PRICE_WIDTH){1'b0}}, b3.high});
    sl  = $signed({{(LV_W-PRICE_WIDTH){1'b0}}, b3.low});
    sc  = $signed({{(LV_W-PRICE_WIDTH){1'b0}}, b3.close});
    sr  = $signed({{(LV_W-RANGE_W){b3.day_range[RANGE_W-1]}}, b3.day_range});
    st0 = $signed({{(LV_W-TERM_W){b3.t0[TERM_W-1]}}, b3.t0});
    st1 = $signed({{(LV_W-TERM_W){b3.t1[TERM_W-1]}}, b3.t1});
    st2 = $signed({{(LV_W-TERM_W){b3.t2[TERM_W-1]}}, b3.t2});
    lv[LVL_P] = sp;
    case (pivot_method)
      METHOD_FIBONACCI: begin
        lv[LVL_R1] = sp + st0;
        lv[LVL_R2] = sp + st1;
        lv[LVL_R3] = sp + st2;
        lv[LVL_S1] = sp - st0;
        lv[LVL_S2] = sp - st1;
        lv[LVL_S3] = sp - st2;
      end
      METHOD_CAMARILLA: begin
        lv[LVL_R1] = sc + st0;
        lv[LVL_R2] = sc + st1;
        lv[LVL_R3] = sc + st2;
        lv[LVL_S1] = sc - st0;
        lv[LVL_S2] = sc - st1;
        lv[LVL_S3] = sc - st2;
      end
      default: begin
        lv[LVL_R1] = (sp <<< 1) - sl;
        lv[LVL_R2] = sp + sr;
        lv[LVL_R3] = sh + ((sp - sl) <<< 1);
        lv[LVL_S1] = (sp <<< 1) - sh;
        lv[LVL_S2] = sp - sr;
        lv[LVL_S3] = sl - ((sh - sp) <<< 1);
      end
    endcase
    for (int i = 0; i < NUM_LEVELS; i++) begin
      fresh[i] = lv[i][LEVEL_WIDTH-1:0];
      if (b3.form) begin
        shown[i] = fresh[i];
      end else if (levels_ready) begin
        shown[i] = held[i];
      end else begin
        shown[i] = '0;
      end
    end
    pivot_next.levels_valid  = b3.form || levels_ready;
    pivot_next.pivot_level   = shown[LVL_P];
    pivot_next.resist_one    = shown[LVL_R1];
    pivot_next.resist_two    = shown[LVL_R2];
    pivot_next.resist_three  = shown[LVL_R3];
    pivot_next.support_one   = shown[LVL_S1];
    pivot_next.support_two   = shown[LVL_S2];
    pivot_next.support_three = shown[LVL_S3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot_valid  <= 1'b0;
      levels_ready <= 1'b0;
    end else if (out_ready) begin
      pivot_valid <= b3_valid;
      if (b3_valid && b3.form) levels_ready <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && b3_valid) begin
      pivot <= pivot_next;
      if (b3.form) held <= fresh;
    end
  end

endmodule

// ===== sv/dpl_checker.sv =====
module dpl_checker import dpl_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   pivot_valid,
  input logic   pivot_stall,
  input pivot_t pivot
);

  logic seen_levels;

  // Once a finished day has been reported, every later result carries levels.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_levels <= 1'b0;
    end else if (pivot_valid && !pivot_stall && pivot.levels_valid) begin
      seen_levels <= 1'b1;
    end
  end

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    pivot_valid && pivot_stall |=> pivot_valid)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    pivot_valid && pivot_stall |=> $stable(pivot))
    else $error("stalled result changed");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !pivot_valid)
    else $error("result shown right after reset");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    pivot_valid && !pivot.levels_valid |->
      pivot.pivot_level == '0 && pivot.resist_one == '0 && pivot.resist_two == '0 &&
      pivot.resist_three == '0 && pivot.support_one == '0 &&
      pivot.support_two == '0 && pivot.support_three == '0)
    else $error("invalid result carries nonzero levels");

  a_levels_stay_valid: assert property (@(posedge clk) disable iff (rst)
    pivot_valid && seen_levels |-> pivot.levels_valid)
    else $error("levels became invalid after a finished day");

endmodule

bind daily_pivot_levels_top dpl_checker u_dpl_checker (
  .clk         (clk),
  .rst         (rst),
  .pivot_valid (pivot_valid),
  .pivot_stall (pivot_stall),
  .pivot       (pivot)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

import dpl_pkg::*;

localparam logic [2:0] ADDR_METHOD = 3'd0;
localparam logic [2:0] ADDR_OFFSET = 3'd4;
// Code 3 has no formula of its own and must behave as the standard one.
localparam logic [METHOD_WIDTH-1:0] METHOD_UNUSED = 2'd3;

class pivot_scoreboard;
  logic [METHOD_WIDTH-1:0] method = METHOD_STANDARD;
  longint                  offset = 0;
  bit                      have_day = 1'b0;
  bit                      levels_ready = 1'b0;
  longint                  cur_day = 0;
  logic [PRICE_WIDTH-1:0]  day_hi = '0;
  logic [PRICE_WIDTH-1:0]  day_lo = '0;
  logic [PRICE_WIDTH-1:0]  day_cl = '0;
  level_t                  held[NUM_LEVELS];
  longint                  fib_q16[3] = '{25035, 40501, 65536};
  longint                  cam_q16[3] = '{6007, 12015, 18022};
  string                   field_names[8] = '{"levels_valid", "pivot_level", "resist_one",
                                              "resist_two", "resist_three", "support_one",
                                              "support_two", "support_three"};
  pivot_t                  expected_q[$];
  int                      errors = 0;
  int                      checked = 0;
  int                      days_formed = 0;

  function void configure(logic [2:0] addr, logic [31:0] data);
    if (addr == ADDR_METHOD) begin
      method = data[METHOD_WIDTH-1:0];
    end else if (addr == ADDR_OFFSET) begin
      offset = longint'($signed(data[OFFSET_WIDTH-1:0]));
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_candle(candle_t c);
    longint secs, day, h, l, cl, p, r, t;
    longint lv[NUM_LEVELS];
    pivot_t want;
    secs = longint'(c.timestamp) + offset;
    day = (secs >= 0) ? secs / 86400 : -((86399 - secs) / 86400);
    if (have_day && day == cur_day) begin
      if (c.high_price > day_hi) day_hi = c.high_price;
      if (c.low_price < day_lo) day_lo = c.low_price;
      day_cl = c.close_price;
    end else begin
      // Any change of bucket closes the day, whichever direction time moved.
      if (have_day) begin
        h = longint'(day_hi);
        l = longint'(day_lo);
        cl = longint'(day_cl);
        p = (h + l + cl) / 3;
        r = h - l;
        lv[LVL_P] = p;
        case (method)
          METHOD_FIBONACCI: begin
            for (int i = 0; i < 3; i++) begin
              t = (fib_q16[i] * r) >>> 16;
              lv[LVL_R1 + i] = p + t;
              lv[LVL_S1 + i] = p - t;
            end
          end
          METHOD_CAMARILLA: begin
            for (int i = 0; i < 3; i++) begin
              t = (cam_q16[i] * r) >>> 16;
              lv[LVL_R1 + i] = cl + t;
              lv[LVL_S1 + i] = cl - t;
            end
          end
          default: begin
            lv[LVL_R1] = 2 * p - l;
            lv[LVL_R2] = p + r;
            lv[LVL_R3] = h + 2 * (p - l);
            lv[LVL_S1] = 2 * p - h;
            lv[LVL_S2] = p - r;
            lv[LVL_S3] = l - 2 * (h - p);
          end
        endcase
        for (int i = 0; i < NUM_LEVELS; i++) held[i] = level_t'(lv[i]);
        levels_ready = 1'b1;
        days_formed++;
      end
      have_day = 1'b1;
      cur_day = day;
      day_hi = c.high_price;
      day_lo = c.low_price;
      day_cl = c.close_price;
    end
    want = '0;
    if (levels_ready) begin
      want.levels_valid = 1'b1;
      want.pivot_level = held[LVL_P];
      want.resist_one = held[LVL_R1];
      want.resist_two = held[LVL_R2];
      want.resist_three = held[LVL_R3];
      want.support_one = held[LVL_S1];
      want.support_two = held[LVL_S2];
      want.support_three = held[LVL_S3];
    end
    expected_q.insert(expected_q.size(), want);
  endfunction

  function logic [LEVEL_WIDTH-1:0] field_of(pivot_t v, int i);
    case (i)
      0: return LEVEL_WIDTH'(v.levels_valid);
      1: return v.pivot_level;
      2: return v.resist_one;
      3: return v.resist_two;
      4: return v.resist_three;
      5: return v.support_one;
      6: return v.support_two;
      default: return v.support_three;
    endcase
  endfunction

  function void check_pivot(pivot_t got);
    pivot_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("result %h arrived with nothing pending", got);
      return;
    end
    want = expected_q.pop_front();
    checked++;
    for (int i = 0; i < 8; i++) begin
      if (field_of(want, i) !== field_of(got, i)) begin
        errors++;
        if (errors <= 10) begin
          $display("result %0d %s: expected %h, got %h", checked, field_names[i],
                   field_of(want, i), field_of(got, i));
        end
      end
    end
  endfunction
endclass

module tb;
  localparam longint TS_MAX = 64'd68719476735;
  localparam logic [PRICE_WIDTH-1:0] PRICE_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  candle_valid = 1'b0;
  logic                  candle_stall;
  candle_t               candle = '0;
  logic                  pivot_valid;
  logic                  pivot_stall = 1'b0;
  pivot_t                pivot;

  pivot_scoreboard book = new();
  bit                    idle_on = 1'b1;
  int                    rx_wait = 0;
  int                    sent = 0;
  int                    reg_errors = 0;

  daily_pivot_levels_top dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .candle_valid(candle_valid),
    .candle_stall(candle_stall),
    .candle      (candle),
    .pivot_valid (pivot_valid),
    .pivot_stall (pivot_stall),
    .pivot       (pivot)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Result side: check each transaction, then hold stall for a drawn number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      pivot_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (pivot_valid && !pivot_stall) begin
        book.check_pivot(pivot);
        rx_wait = idle_on ? $urandom_range(0, 6) : 0;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        pivot_stall <= 1'b1;
      end else begin
        pivot_stall <= 1'b0;
      end
    end
  end

  function automatic logic [PRICE_WIDTH-1:0] rand_price(int bits);
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[PRICE_WIDTH-1:0] >> (PRICE_WIDTH - bits);
  endfunction

  task automatic send_candle(input candle_t c);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      candle_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    candle_valid <= 1'b1;
    candle <= c;
    do @(posedge clk); while (candle_stall);
    book.note_candle(c);
    sent++;
  endtask

  task automatic drain();
    candle_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] mask, back;
    mask = (addr == ADDR_METHOD) ? 32'h3 : 32'h3FFFF;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    book.configure(addr, data);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    back = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if ((back & mask) !== (data & mask)) begin
      reg_errors++;
      $display("register at %0d: wrote %h, read back %h", addr, data, back);
    end
  endtask

  task automatic random_phase(input logic [METHOD_WIDTH-1:0] method, input int off,
                              input int n, input bit hold_midway);
    longint dmin, dmax, seq_day, span_lo, span_hi;
    int left, bits, pick;
    candle_t c;
    logic [PRICE_WIDTH-1:0] tmp;
    drain();
    write_register(ADDR_METHOD, 32'(method));
    write_register(ADDR_OFFSET, 32'(off));
    dmin = (off < 0) ? -1 : 0;
    dmax = (TS_MAX + off) / 86400;
    seq_day = dmin + $urandom_range(0, 40);
    left = 0;
    bits = PRICE_WIDTH;
    for (int k = 0; k < n; k++) begin
      if (k % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (hold_midway && k == n / 2) drain();
      if ($urandom_range(0, 12) == 0) begin
        // Noise: a candle from anywhere, which usually breaks the running day.
        c.timestamp = TS_WIDTH'({$urandom(), $urandom()});
        c.high_price = rand_price(PRICE_WIDTH);
        c.low_price = rand_price(PRICE_WIDTH);
        c.close_price = rand_price(PRICE_WIDTH);
      end else begin
        if (left == 0) begin
          pick = $urandom_range(0, 9);
          if (pick < 6) begin
            seq_day++;
          end else if (pick == 6) begin
            seq_day += $urandom_range(2, 500);
          end else if (pick == 7) begin
            seq_day -= $urandom_range(1, 3);
          end else begin
            seq_day = dmin + $urandom_range(0, int'(dmax - dmin));
          end
          if (seq_day < dmin || seq_day > dmax) seq_day = dmin + $urandom_range(0, 20);
          left = $urandom_range(1, 8);
          bits = ($urandom_range(0, 3) == 0) ? PRICE_WIDTH : $urandom_range(4, PRICE_WIDTH);
        end
        left--;
        span_lo = seq_day * 86400 - off;
        span_hi = span_lo + 86399;
        if (span_lo < 0) span_lo = 0;
        if (span_hi > TS_MAX) span_hi = TS_MAX;
        c.timestamp = TS_WIDTH'(span_lo + $urandom_range(0, int'(span_hi - span_lo)));
        c.high_price = rand_price(bits);
        c.low_price = rand_price(bits);
        if (c.low_price > c.high_price && $urandom_range(0, 4) != 0) begin
          tmp = c.low_price;
          c.low_price = c.high_price;
          c.high_price = tmp;
        end
        c.close_price = rand_price(bits);
      end
      send_candle(c);
    end
  endtask

  initial begin
    candle_t c;
    logic [TS_WIDTH-1:0] dir_ts[5];
    int dir_offsets[4];
    logic [METHOD_WIDTH-1:0] method_codes[4];
    int off;
    dir_ts = '{36'd0, 36'd86399, 36'd86400, TS_WIDTH'(TS_MAX), 36'd100};
    dir_offsets = '{0, -86400, 86400, -1};
    method_codes = '{METHOD_STANDARD, METHOD_FIBONACCI, METHOD_CAMARILLA, METHOD_UNUSED};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Each group crosses day boundaries with extreme prices, including a finished day
    // whose low is above its high, a jump to the last second and a step back in time.
    for (int g = 0; g < 4; g++) begin
      drain();
      write_register(ADDR_METHOD, 32'(method_codes[g]));
      write_register(ADDR_OFFSET, 32'(dir_offsets[g]));
      for (int k = 0; k < 5; k++) begin
        c.timestamp = dir_ts[k];
        case (k)
          0: begin
            c.high_price = PRICE_MAX;
            c.low_price = '0;
            c.close_price = PRICE_MAX;
          end
          1: begin
            c.high_price = '0;
            c.low_price = PRICE_MAX;
            c.close_price = rand_price(PRICE_WIDTH);
          end
          2: begin
            c.high_price = '0;
            c.low_price = PRICE_MAX;
            c.close_price = '0;
          end
          3: begin
            c.high_price = rand_price(PRICE_WIDTH);
            c.low_price = rand_price(PRICE_WIDTH);
            c.close_price = rand_price(PRICE_WIDTH);
          end
          default: begin
            c.high_price = PRICE_MAX;
            c.low_price = PRICE_MAX;
            c.close_price = '0;
          end
        endcase
        send_candle(c);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: off = int'($urandom_range(0, 172800)) - 86400;
        1: off = 86400;
        2: off = -86400;
        default: off = 0;
      endcase
      random_phase(method_codes[(ph + ph / 4) % 4], off, 192, ph == 2);
    end

    drain();
    repeat (4) @(posedge clk);
    $display("covered %0d candles, %0d results checked, %0d finished days turned into levels",
             sent, book.checked, book.days_formed);
    $display("all four method codes, offsets of -86400, -1, 0, 86400 and random, both sides idling");
    if (book.pending() != 0) $display("%0d results never arrived", book.pending());
    if (book.errors == 0 && book.pending() == 0 && reg_errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
sv/dpl_pkg.sv
sv/dpl_front.sv
sv/dpl_fifo.sv
sv/dpl_back.sv
sv/daily_pivot_levels_top.sv
sv/dpl_checker.sv
verif/tb.sv
